@@ hw/rtl/tbmm_pkg.sv @@
// Shared types and constants of the time-bucket min/max aggregator.
// No dependencies; tbmm_front, tbmm_back and the top level import this package.
package tbmm_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 60;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned SUM_W   = 48;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned BW_W    = 17;
    localparam int unsigned OLD_W   = 34;
    localparam logic [BW_W-1:0] BW_RESET = 17'd60;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [2:0] ADDR_WIDTH_REG = 3'd0;

    // Classified item passed from the front to the back.
    typedef struct packed {
        logic              op;
        logic [TIME_W-1:0] start;
        logic [VAL_W-1:0]  value;
    } t_cmd;

    // One bucket as kept in the ring.
    typedef struct packed {
        logic [TIME_W-1:0] start;
        logic [SUM_W-1:0]  sum;
        logic [VAL_W-1:0]  min;
        logic [VAL_W-1:0]  max;
        logic [CNT_W-1:0]  count;
    } t_bucket;

    // One result item.
    typedef struct packed {
        t_bucket b;
        logic    is_open;
        logic    valid;
        logic    last;
    } t_res;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ADD,
        B_REQ,
        B_CHK,
        B_OPEN,
        B_FLUSH
    } t_bstate;

endpackage

@@ hw/rtl/tbmm_fifo.sv @@
// Two-entry queue used between front and back and on the result side.
// Depends on nothing but its width parameter.
module tbmm_fifo #(
    parameter int unsigned W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_din,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_dout,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         w_wr, w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_dout  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_din;
    end
endmodule

@@ hw/rtl/tbmm_front.sv @@
// Front part: accepts items and finds the bucket start by a serial remainder.
// Depends on tbmm_pkg.
module tbmm_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [tbmm_pkg::BW_W-1:0] i_width,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic                      i_operation,
    input  logic [31:0]               i_time_sec,
    input  logic signed [31:0]        i_sample_value,
    output logic                      o_cmd_push,
    output tbmm_pkg::t_cmd            o_cmd,
    input  logic                      i_cmd_full
);
    import tbmm_pkg::*;

    t_fstate         r_state, n_state;
    logic [4:0]      r_cnt;
    logic [TIME_W-1:0] r_t, r_dvd;
    logic [BW_W-1:0] r_rem;
    logic            r_op;
    logic [VAL_W-1:0] r_val;
    logic [BW_W:0]   w_rem_sh;
    logic            w_ge;

    // One restoring step per cycle.
    assign w_rem_sh = {r_rem, r_dvd[TIME_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, i_width});

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_push) n_state = F_DIV;
            F_DIV:  if (r_cnt == 5'd31) n_state = F_PUSH;
            F_PUSH: if (!i_cmd_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_full     = (r_state != F_IDLE);
        o_cmd_push = (r_state == F_PUSH);
        o_cmd.op    = r_op;
        o_cmd.start = r_t - {{(TIME_W-BW_W){1'b0}}, r_rem};
        o_cmd.value = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= 5'd0;
        end else begin
            r_state <= n_state;
            if (r_state == F_DIV) r_cnt <= r_cnt + 5'd1;
            else r_cnt <= 5'd0;
        end
    end

    // Divider datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_t   <= i_time_sec;
            r_dvd <= i_time_sec;
            r_rem <= '0;
            r_op  <= i_operation;
            r_val <= i_sample_value;
        end else if (r_state == F_DIV) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= w_ge ? BW_W'(w_rem_sh - {1'b0, i_width}) : w_rem_sh[BW_W-1:0];
        end
    end
endmodule

@@ hw/rtl/tbmm_back.sv @@
// Back part: keeps the open bucket and the ring, and walks the ring on reads.
// Depends on tbmm_pkg.
module tbmm_back #(
    parameter int unsigned HISTORY_DEPTH = tbmm_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [tbmm_pkg::BW_W-1:0] i_width,
    input  logic                      i_cmd_empty,
    input  tbmm_pkg::t_cmd            i_cmd,
    output logic                      o_cmd_pop,
    output logic                      o_res_push,
    output tbmm_pkg::t_res            o_res,
    input  logic                      i_res_full
);
    import tbmm_pkg::*;

    localparam int unsigned SW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(HISTORY_DEPTH);
    localparam logic [SW:0]   DEPTH_S = (SW+1)'(HISTORY_DEPTH);

    t_bstate          r_state, n_state;
    t_cmd             r_cmd;
    logic             r_have_open;
    t_bucket          r_open;
    logic [SW-1:0]    r_head, r_slot;
    logic [FW-1:0]    r_fill, r_idx;
    logic signed [OLD_W-1:0] r_oldest;
    t_res             r_pend;
    logic             r_pend_v;
    t_bucket          r_mem [HISTORY_DEPTH];
    t_bucket          r_rdata;

    logic             w_new;
    logic [SW-1:0]    w_wslot;
    logic [SW:0]      w_sum_slot;
    logic [SUM_W:0]   w_sum;
    logic [SUM_W-1:0] w_sum_sat;
    logic             w_qual_ring, w_qual_open, w_qual, w_stall;
    logic             w_mem_we, w_mem_re;
    t_bucket          w_cand;
    logic [SW-1:0]    w_next_slot;

    // Add decision and saturating fold.
    assign w_new = !r_have_open || (r_cmd.start > r_open.start);
    assign w_sum = {r_open.sum[SUM_W-1], r_open.sum}
                 + {{(SUM_W-VAL_W+1){r_cmd.value[VAL_W-1]}}, r_cmd.value};
    always_comb begin
        if (w_sum[SUM_W] != w_sum[SUM_W-1])
            w_sum_sat = w_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        else
            w_sum_sat = w_sum[SUM_W-1:0];
    end

    // Ring slot for a closing bucket.
    assign w_sum_slot = {1'b0, r_head} + (SW+1)'(r_fill);
    always_comb begin
        if (r_fill < DEPTH_F)
            w_wslot = (w_sum_slot >= DEPTH_S) ? SW'(w_sum_slot - DEPTH_S) : w_sum_slot[SW-1:0];
        else
            w_wslot = r_head;
    end

    assign w_next_slot = ((SW+1)'(r_slot) + 1'b1 >= DEPTH_S) ? '0 : SW'(r_slot + 1'b1);

    // Window checks.
    assign w_qual_ring = $signed({2'b00, r_rdata.start}) > r_oldest;
    assign w_qual_open = r_have_open && ($signed({2'b00, r_open.start}) > r_oldest);
    assign w_qual  = (r_state == B_CHK) ? w_qual_ring : w_qual_open;
    assign w_cand  = (r_state == B_CHK) ? r_rdata : r_open;
    assign w_stall = w_qual && r_pend_v && i_res_full;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_cmd_empty) n_state = (i_cmd.op == OP_ADD) ? B_ADD : B_IDLE;
                if (!i_cmd_empty && i_cmd.op == OP_READ)
                    n_state = (r_fill != '0) ? B_REQ : B_OPEN;
            end
            B_ADD:  n_state = B_IDLE;
            B_REQ:  n_state = B_CHK;
            B_CHK:  if (!w_stall) n_state = (r_idx + 1'b1 == r_fill) ? B_OPEN : B_REQ;
            B_OPEN: if (!w_stall) n_state = B_FLUSH;
            B_FLUSH: if (!i_res_full) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd_pop  = (r_state == B_IDLE);
        w_mem_we   = (r_state == B_ADD) && w_new && r_have_open;
        w_mem_re   = (r_state == B_REQ);
        o_res_push = 1'b0;
        o_res      = r_pend;
        o_res.last = 1'b0;
        unique case (r_state)
            B_CHK, B_OPEN: o_res_push = w_qual && r_pend_v && !i_res_full;
            B_FLUSH: begin
                o_res_push = 1'b1;
                o_res.last = 1'b1;
                if (!r_pend_v) o_res = '{b: '0, is_open: 1'b0, valid: 1'b0, last: 1'b1};
            end
            default: o_res_push = 1'b0;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_have_open <= 1'b0;
            r_open      <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_pend_v    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_ADD) begin
                if (w_new) begin
                    if (r_have_open) begin
                        if (r_fill < DEPTH_F) r_fill <= r_fill + 1'b1;
                        else r_head <= ((SW+1)'(r_head) + 1'b1 >= DEPTH_S) ? '0
                                                                          : SW'(r_head + 1'b1);
                    end
                    r_have_open  <= 1'b1;
                    r_open.start <= r_cmd.start;
                    r_open.sum   <= {{(SUM_W-VAL_W){r_cmd.value[VAL_W-1]}}, r_cmd.value};
                    r_open.min   <= r_cmd.value;
                    r_open.max   <= r_cmd.value;
                    r_open.count <= CNT_W'(1);
                end else begin
                    r_open.sum <= w_sum_sat;
                    if ($signed(r_cmd.value) < $signed(r_open.min)) r_open.min <= r_cmd.value;
                    if ($signed(r_cmd.value) > $signed(r_open.max)) r_open.max <= r_cmd.value;
                    if (r_open.count != {CNT_W{1'b1}}) r_open.count <= r_open.count + 1'b1;
                end
            end
            if (r_state == B_IDLE) r_pend_v <= 1'b0;
            else if ((r_state == B_CHK || r_state == B_OPEN) && w_qual && !w_stall)
                r_pend_v <= 1'b1;
        end
    end

    // Read walk datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && !i_cmd_empty) begin
            r_cmd    <= i_cmd;
            r_idx    <= '0;
            r_slot   <= r_head;
            r_oldest <= $signed({2'b00, i_cmd.start})
                      - $signed(OLD_W'(i_width) * OLD_W'(HISTORY_DEPTH));
        end else if (r_state == B_CHK && !w_stall) begin
            r_idx  <= r_idx + 1'b1;
            r_slot <= w_next_slot;
        end
        if ((r_state == B_CHK || r_state == B_OPEN) && w_qual && !w_stall) begin
            r_pend.b       <= w_cand;
            r_pend.is_open <= (r_state == B_OPEN);
            r_pend.valid   <= 1'b1;
            r_pend.last    <= 1'b0;
        end
    end

    // Ring memory.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_wslot] <= r_open;
        if (w_mem_re) r_rdata <= r_mem[r_slot];
    end
endmodule

@@ hw/rtl/time_bucket_min_max_aggregator.sv @@
// Top level of the time-bucket min/max aggregator: config register, front,
// command queue, back and result queue. Depends on tbmm_pkg and the tbmm_* modules.
//
// Usage: items enter through push/full and results leave through empty/pop.
// An add item (operation 0) folds a sample into the open bucket or closes it
// into the history ring and opens a new one; it gives no result. A read item
// (operation 1) gives every kept bucket newer than the window, oldest first,
// then the open bucket, with last set on the final item, or one item with
// valid_res low when nothing qualifies.
// Flow: the front works out a serial remainder and then pushes the item; it
// takes no new item until it has pushed the last one. An add passes through
// the back's add state; a read checks each kept ring entry, then the open bucket.
// bucket_width is written over the APB port at address 0; the user must write
// it only while idle, as the block itself does not enforce this; 0 acts as 1.
// Reset clears the open bucket, ring head and fill count and sets the width
// to 60; ring contents need no clearing. A stalled receiver fills the result
// queue and then holds the read walk, and in turn the front.
module time_bucket_min_max_aggregator #(
    parameter int unsigned HISTORY_DEPTH = tbmm_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                push,
    output logic                full,
    input  logic                i_operation,
    input  logic [31:0]         i_time_sec,
    input  logic signed [31:0]  i_sample_value,
    output logic                empty,
    input  logic                pop,
    output logic [31:0]         o_bucket_start,
    output logic signed [47:0]  o_bucket_sum,
    output logic signed [31:0]  o_bucket_min,
    output logic signed [31:0]  o_bucket_max,
    output logic [15:0]         o_bucket_count,
    output logic                o_is_open,
    output logic                o_valid_res,
    output logic                o_last
);
    import tbmm_pkg::*;

    logic [BW_W-1:0] r_width;
    logic [BW_W-1:0] w_eff;
    logic            w_cmd_push, w_cmd_full, w_cmd_empty, w_cmd_pop;
    t_cmd            w_cmd_in, w_cmd_out;
    logic            w_res_push, w_res_full;
    t_res            w_res_in, w_res_out;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WIDTH_REG) ? {{(32-BW_W){1'b0}}, r_width} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_width <= BW_RESET;
        else if (psel && penable && pwrite && pready && paddr == ADDR_WIDTH_REG)
            r_width <= pwdata[BW_W-1:0];
    end
    assign w_eff = (r_width == '0) ? BW_W'(1) : r_width;

    tbmm_front u_front (
        .i_clk, .i_rst_n, .i_width(w_eff), .i_push(push), .o_full(full),
        .i_operation, .i_time_sec, .i_sample_value,
        .o_cmd_push(w_cmd_push), .o_cmd(w_cmd_in), .i_cmd_full(w_cmd_full)
    );

    tbmm_fifo #(.W($bits(t_cmd))) u_cmd_q (
        .i_clk, .i_rst_n, .i_push(w_cmd_push), .i_din(w_cmd_in), .o_full(w_cmd_full),
        .i_pop(w_cmd_pop), .o_dout(w_cmd_out), .o_empty(w_cmd_empty)
    );

    tbmm_back #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_width(w_eff), .i_cmd_empty(w_cmd_empty), .i_cmd(w_cmd_out),
        .o_cmd_pop(w_cmd_pop), .o_res_push(w_res_push), .o_res(w_res_in),
        .i_res_full(w_res_full)
    );

    tbmm_fifo #(.W($bits(t_res))) u_res_q (
        .i_clk, .i_rst_n, .i_push(w_res_push), .i_din(w_res_in), .o_full(w_res_full),
        .i_pop(pop), .o_dout(w_res_out), .o_empty(empty)
    );

    assign o_bucket_start = w_res_out.b.start;
    assign o_bucket_sum   = w_res_out.b.sum;
    assign o_bucket_min   = w_res_out.b.min;
    assign o_bucket_max   = w_res_out.b.max;
    assign o_bucket_count = w_res_out.b.count;
    assign o_is_open      = w_res_out.is_open;
    assign o_valid_res    = w_res_out.valid;
    assign o_last         = w_res_out.last;

    // An accepted item keeps the front busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full) |=> full) else $error("front not busy after accept");

    // The empty-window marker always closes its read.
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_valid_res) |-> o_last) else $error("marker without last");

    // The open bucket is always the final item of a read.
    a_open_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_is_open) |-> o_last) else $error("open bucket not last");
endmodule
